[hdl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wheel speed pi loop
// register index codes, configuration record, sequencer states and commands
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  // default fixed point formats
  localparam int SPEED_FRAC_BITS_DEF = 12;
  localparam int ACC_FRAC_BITS_DEF   = 8;

  // count_scale and gains are Q.12
  localparam int SCALE_FRAC_BITS = 12;
  localparam int GAIN_FRAC_BITS  = 12;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;

  // filter weight of one
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // register reset values
  localparam logic [15:0] COUNT_SCALE_RESET   = 16'd4096;
  localparam logic [14:0] SPEED_LIMIT_RESET   = 15'd8192;
  localparam logic [16:0] FILTER_ALPHA_RESET  = 17'd32768;
  localparam logic [23:0] PROP_GAIN_RESET     = 24'd4096;
  localparam logic [23:0] INTEGRAL_GAIN_RESET = 24'd4096;
  localparam logic [12:0] PWM_LIMIT_RESET     = 13'd7200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_COUNT_SCALE,
    CFG_SPEED_LIMIT,
    CFG_FILTER_ALPHA,
    CFG_PROP_GAIN,
    CFG_INTEGRAL_GAIN,
    CFG_REVERSE_POLARITY,
    CFG_PWM_LIMIT
  } wsp_cfg_idx_t;

  typedef struct packed {
    logic [15:0] count_scale;
    logic [14:0] speed_limit;
    logic [16:0] filter_alpha;
    logic [23:0] prop_gain;
    logic [23:0] integral_gain;
    logic        reverse_polarity;
    logic [12:0] pwm_limit;
  } wsp_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_FILT,
    ST_MUL_PROP,
    ST_MUL_INT,
    ST_ACC,
    ST_OUT
  } wsp_state_t;

  typedef enum logic [2:0] {
    MUL_COUNT,
    MUL_NEW,
    MUL_OLD,
    MUL_PROP,
    MUL_INT
  } wsp_mul_sel_t;

  typedef enum logic {
    SUM_FILT,
    SUM_INC
  } wsp_sum_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    wsp_mul_sel_t mul_sel;
    logic         raw_en;
    logic         sum_en;
    wsp_sum_sel_t sum_sel;
    logic         filt_en;
    logic         acc_en;
    logic         out_load;
  } wsp_cmd_t;

  typedef struct packed {
    logic out_hold;
  } wsp_status_t;

endpackage

`default_nettype wire

[hdl/wsp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wsp_cfg_regs: configuration register file
// seven write-only registers, low bits of the write data are kept
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [wsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [wsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output wsp_pkg::wsp_cfg_t                   cfg
);
  import wsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_scale      <= COUNT_SCALE_RESET;
      cfg.speed_limit      <= SPEED_LIMIT_RESET;
      cfg.filter_alpha     <= FILTER_ALPHA_RESET;
      cfg.prop_gain        <= PROP_GAIN_RESET;
      cfg.integral_gain    <= INTEGRAL_GAIN_RESET;
      cfg.reverse_polarity <= 1'b0;
      cfg.pwm_limit        <= PWM_LIMIT_RESET;
    end else if (cfg_we) begin
      case (wsp_cfg_idx_t'(cfg_addr))
        CFG_COUNT_SCALE:      cfg.count_scale      <= cfg_wdata[15:0];
        CFG_SPEED_LIMIT:      cfg.speed_limit      <= cfg_wdata[14:0];
        CFG_FILTER_ALPHA:     cfg.filter_alpha     <= cfg_wdata[16:0];
        CFG_PROP_GAIN:        cfg.prop_gain        <= cfg_wdata[23:0];
        CFG_INTEGRAL_GAIN:    cfg.integral_gain    <= cfg_wdata[23:0];
        CFG_REVERSE_POLARITY: cfg.reverse_polarity <= cfg_wdata[0];
        CFG_PWM_LIMIT:        cfg.pwm_limit        <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/wsp_ctrl.sv]
// ----------------------------------------------------------------------------
// wsp_ctrl: sequencer of the speed loop
// steps one item through the shared multiplier and the update stages
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wsp_pkg::wsp_status_t      status,
  output wsp_pkg::wsp_cmd_t         cmd
);
  import wsp_pkg::*;

  wsp_state_t state;
  wsp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_RAW;
      ST_RAW:      state_next = ST_MUL_NEW;
      ST_MUL_NEW:  state_next = ST_MUL_OLD;
      ST_MUL_OLD:  state_next = ST_FILT;
      ST_FILT:     state_next = ST_MUL_PROP;
      ST_MUL_PROP: state_next = ST_MUL_INT;
      ST_MUL_INT:  state_next = ST_ACC;
      ST_ACC:      state_next = ST_OUT;
      ST_OUT:      if (!status.out_hold) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_in = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_COUNT;
        end
      end
      ST_RAW: begin
        cmd.raw_en = 1'b1;
      end
      ST_MUL_NEW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NEW;
      end
      ST_MUL_OLD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OLD;
        cmd.sum_en  = 1'b1;
        cmd.sum_sel = SUM_FILT;
      end
      ST_FILT: begin
        cmd.filt_en = 1'b1;
      end
      ST_MUL_PROP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PROP;
      end
      ST_MUL_INT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INT;
        cmd.sum_en  = 1'b1;
        cmd.sum_sel = SUM_INC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = !status.out_hold;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/wsp_datapath.sv]
// ----------------------------------------------------------------------------
// wsp_datapath: speed filter and incremental pi datapath
// one shared 25x18 multiplier, filter and accumulator state, output register
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_datapath #(
  parameter int SPEED_FRAC_BITS = wsp_pkg::SPEED_FRAC_BITS_DEF,
  parameter int ACC_FRAC_BITS   = wsp_pkg::ACC_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wsp_pkg::wsp_cfg_t        cfg,
  input  wsp_pkg::wsp_cmd_t        cmd,
  output wsp_pkg::wsp_status_t     status,
  input  wire logic signed [15:0]  encoder_count,
  input  wire logic signed [13:0]  target_speed,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [12:0]              pwm_duty,
  output logic                     reverse_drive,
  output logic signed [15:0]       measured_speed,
  output logic                     stopped
);
  import wsp_pkg::*;

  localparam int AccW     = 13 + ACC_FRAC_BITS + 1;
  localparam int AddW     = SUM_W + 1;
  localparam int IncShift = GAIN_FRAC_BITS + SPEED_FRAC_BITS - ACC_FRAC_BITS;
  localparam int OneSpeedI = 1 << SPEED_FRAC_BITS;
  localparam logic signed [16:0] OneSpeed = 17'(OneSpeedI);
  localparam logic signed [SUM_W-1:0] IncHalf = SUM_W'(64'(1) << (IncShift - 1));
  localparam logic signed [SUM_W-1:0] FiltHalf = SUM_W'(32768);

  // state and working registers
  logic signed [13:0]        target;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [15:0]        raw;
  logic signed [15:0]        filt;
  logic signed [AccW-1:0]    acc;
  logic signed [16:0]        prev_err;
  logic                      stop_flag;

  // combinational
  logic [16:0]               alpha_c;
  logic [16:0]               alpha_rest;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [21:0]        raw_w;
  logic signed [21:0]        raw_n;
  logic signed [21:0]        lim;
  logic signed [15:0]        raw_next;
  logic signed [16:0]        err;
  logic signed [17:0]        diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   inc_sh;
  logic signed [AddW-1:0]    acc_sum;
  logic signed [AddW-1:0]    bound;
  logic signed [AccW-1:0]    acc_next;
  logic                      stop_cond;
  logic [AccW-1:0]           acc_abs;
  logic [AccW-1:0]           duty_w;
  logic [12:0]               duty_next;

  assign status.out_hold = out_valid && !out_ready;

  // filter weight above one acts as one
  assign alpha_c    = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
  assign alpha_rest = ALPHA_ONE - alpha_c;

  // raw speed: floor scale, polarity, clamp
  always_comb begin
    prod_sh = prod >>> SCALE_FRAC_BITS;
    raw_w   = $signed(prod_sh[21:0]);
    raw_n   = cfg.reverse_polarity ? -raw_w : raw_w;
    lim     = $signed(22'({1'b0, cfg.speed_limit}));
    if (raw_n > lim) begin
      raw_next = lim[15:0];
    end else if (raw_n < -lim) begin
      raw_next = $signed(16'(-lim));
    end else begin
      raw_next = raw_n[15:0];
    end
  end

  assign err  = 17'(target) - 17'(filt);
  assign diff = 18'(err) - 18'(prev_err);

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_COUNT: begin
        mul_a = $signed(MUL_A_W'({1'b0, cfg.count_scale}));
        mul_b = MUL_B_W'(encoder_count);
      end
      MUL_NEW: begin
        mul_a = $signed(MUL_A_W'({1'b0, alpha_c}));
        mul_b = MUL_B_W'(raw);
      end
      MUL_OLD: begin
        mul_a = $signed(MUL_A_W'({1'b0, alpha_rest}));
        mul_b = MUL_B_W'(filt);
      end
      MUL_PROP: begin
        mul_a = $signed(MUL_A_W'({1'b0, cfg.prop_gain}));
        mul_b = diff;
      end
      MUL_INT: begin
        mul_a = $signed(MUL_A_W'({1'b0, cfg.integral_gain}));
        mul_b = MUL_B_W'(err);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // second term joins the partial sum
  assign total = sum + SUM_W'(prod);

  // increment, accumulate, saturate
  assign inc_sh  = total >>> IncShift;
  assign acc_sum = AddW'(acc) + AddW'(inc_sh);
  assign bound   = $signed(AddW'({1'b0, cfg.pwm_limit})) <<< ACC_FRAC_BITS;

  always_comb begin
    if (acc_sum > bound) begin
      acc_next = bound[AccW-1:0];
    end else if (acc_sum < -bound) begin
      acc_next = $signed(AccW'(-bound));
    end else begin
      acc_next = acc_sum[AccW-1:0];
    end
  end

  assign stop_cond = (target == 14'sd0) && (17'(filt) < OneSpeed) &&
                     (17'(filt) > -OneSpeed);

  // drive magnitude truncates toward zero
  assign acc_abs   = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
  assign duty_w    = acc_abs >> ACC_FRAC_BITS;
  assign duty_next = duty_w[12:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target <= target_speed;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.raw_en) begin
      raw <= raw_next;
    end
    if (cmd.sum_en) begin
      sum <= SUM_W'(prod) + ((cmd.sum_sel == SUM_FILT) ? FiltHalf : IncHalf);
    end
    if (cmd.out_load) begin
      pwm_duty       <= duty_next;
      reverse_drive  <= (duty_next != 13'd0) && (acc[AccW-1] ^ cfg.reverse_polarity);
      measured_speed <= filt;
      stopped        <= stop_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt      <= '0;
      acc       <= '0;
      prev_err  <= '0;
      stop_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.filt_en) begin
        filt <= $signed(total[31:16]);
      end
      if (cmd.acc_en) begin
        if (stop_cond) begin
          acc       <= '0;
          prev_err  <= '0;
          stop_flag <= 1'b1;
        end else begin
          acc       <= acc_next;
          prev_err  <= err;
          stop_flag <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/wheel_speed_pi_loop_top.sv]
// ----------------------------------------------------------------------------
// wheel_speed_pi_loop_top: speed loop of one wheel
// usage:
//   s_* channel carries one control tick: encoder count and target speed
//   m_* channel returns the pwm duty, direction, filtered speed and stop flag
//   cfg_we/cfg_addr/cfg_wdata write the seven gain and limit registers,
//   only while no item is in flight
// a new item is taken only once the last one has been loaded into the
//   output register; the shared 25x18 multiplier forms five products per
//   item in sequence, between the scale, clamp, filter and accumulate
//   steps
// s_tready is high only while the sequencer waits for an item; a finished
//   result sits in the output register, so the next item is taken while
//   the receiver stalls; a new result is held back until m_tready frees it
// reset: registers return to their defaults, filtered speed, accumulator
//   and last error clear, the output register empties
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_pi_loop_top #(
  parameter int SPEED_FRAC_BITS = wsp_pkg::SPEED_FRAC_BITS_DEF,
  parameter int ACC_FRAC_BITS   = wsp_pkg::ACC_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input item: encoder_count[15:0], target_speed[29:16], zero pad
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,
  // result item: pwm_duty[12:0], reverse_drive[13], measured_speed[29:14],
  // stopped[30], zero pad
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [wsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [wsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wsp_pkg::*;

  wsp_cfg_t    cfg;
  wsp_cmd_t    cmd;
  wsp_status_t status;

  logic [12:0]        pwm_duty;
  logic               reverse_drive;
  logic signed [15:0] measured_speed;
  logic               stopped;

  wsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: one item at a time
  wsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // the count is read straight from the port in the accept cycle
  wsp_datapath #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .ACC_FRAC_BITS   (ACC_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .encoder_count  ($signed(s_tdata[15:0])),
    .target_speed   ($signed(s_tdata[29:16])),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .pwm_duty       (pwm_duty),
    .reverse_drive  (reverse_drive),
    .measured_speed (measured_speed),
    .stopped        (stopped)
  );

  assign m_tdata = {1'b0, stopped, measured_speed, reverse_drive, pwm_duty};

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wheel speed pi loop
// a cycle-free model of the speed loop (scale, clamp, moving average,
// incremental pi with saturating accumulator, stop rule) predicts every
// result item; a directed table covers the corners and random runs of
// control ticks follow, under several register settings, with random
// gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import wsp_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 12;    // margin after the last result has come back
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no item moving on either side

  // register index outside the map, writes to it must be dropped
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

  // fixed point constants of the loop
  localparam int     INC_SHIFT   = GAIN_FRAC_BITS + SPEED_FRAC_BITS_DEF - ACC_FRAC_BITS_DEF;
  localparam longint INC_HALF    = 64'sd1 <<< (INC_SHIFT - 1);
  localparam longint SPEED_ONE   = 64'sd1 <<< SPEED_FRAC_BITS_DEF;
  localparam longint ALPHA_SCALE = 64'sd65536;
  localparam longint ALPHA_HALF  = 64'sd32768;

  // one result item, laid out as m_tdata[30:0]
  typedef struct packed {
    logic        stopped;
    logic [15:0] measured_speed;
    logic        reverse_drive;
    logic [12:0] pwm_duty;
  } wheel_report_t;

  typedef enum logic {
    ROW_TICK,
    ROW_WRITE
  } row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_ADDR_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic signed [15:0]     count;
    logic signed [13:0]     target;
    logic                   known;   // expected result typed in the table
    wheel_report_t          want;
  } plan_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block ports
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata   = '0;   // encoder_count[15:0], target_speed[29:16]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;          // pwm_duty[12:0], reverse_drive[13],
                                           // measured_speed[29:14], stopped[30]
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wheel_speed_pi_loop_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // loop model: its own register copy and the three state words
  // ---------------------------------------------------------------------------
  wsp_cfg_t loop_cfg;
  longint   filt_speed;
  longint   drive_acc;
  longint   last_error;

  wheel_report_t due_reports[$];   // results owed by the block, oldest first
  plan_row_t     plan[$];
  int            errors      = 0;
  bit            quiet       = 1'b0;  // no gaps and no stalls in this stretch
  int            stall_left  = 0;
  int            idle_cycles = 0;

  // registers keep only their own width, unknown indexes are dropped
  function automatic void store_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_COUNT_SCALE:      loop_cfg.count_scale      = val[15:0];
      CFG_SPEED_LIMIT:      loop_cfg.speed_limit      = val[14:0];
      CFG_FILTER_ALPHA:     loop_cfg.filter_alpha     = val[16:0];
      CFG_PROP_GAIN:        loop_cfg.prop_gain        = val[23:0];
      CFG_INTEGRAL_GAIN:    loop_cfg.integral_gain    = val[23:0];
      CFG_REVERSE_POLARITY: loop_cfg.reverse_polarity = val[0];
      CFG_PWM_LIMIT:        loop_cfg.pwm_limit        = val[12:0];
      default: ;
    endcase
  endfunction

  // one control tick of the speed loop
  function automatic wheel_report_t step_wheel(input logic signed [15:0] count,
                                               input logic signed [13:0] target);
    longint cnt, tgt, scale, lim, alpha, kp, ki, raw, err, inc, bound, mag;
    wheel_report_t rep;
    rep   = '0;
    cnt   = count;
    tgt   = target;
    scale = loop_cfg.count_scale;
    lim   = loop_cfg.speed_limit;
    kp    = loop_cfg.prop_gain;
    ki    = loop_cfg.integral_gain;
    alpha = loop_cfg.filter_alpha;
    // weights above one act as one
    if (alpha > ALPHA_SCALE)
      alpha = ALPHA_SCALE;

    // counts to speed, polarity, clamp
    raw = (cnt * scale) >>> SCALE_FRAC_BITS;
    if (loop_cfg.reverse_polarity)
      raw = -raw;
    if (raw > lim)
      raw = lim;
    if (raw < -lim)
      raw = -lim;

    // moving average, rounded, always updated
    filt_speed = (alpha * raw + (ALPHA_SCALE - alpha) * filt_speed + ALPHA_HALF) >>> 16;
    rep.measured_speed = filt_speed[15:0];

    if (tgt == 0 && filt_speed < SPEED_ONE && filt_speed > -SPEED_ONE) begin
      // stop rule clears the controller
      drive_acc      = 0;
      last_error     = 0;
      rep.stopped    = 1'b1;
    end else begin
      err = tgt - filt_speed;
      inc = kp * (err - last_error) + ki * err;
      inc = (inc + INC_HALF) >>> INC_SHIFT;
      drive_acc = drive_acc + inc;
      bound = longint'(loop_cfg.pwm_limit) <<< ACC_FRAC_BITS_DEF;
      if (drive_acc > bound)
        drive_acc = bound;
      if (drive_acc < -bound)
        drive_acc = -bound;
      last_error = err;
      mag = (drive_acc < 0) ? -drive_acc : drive_acc;
      mag = mag >>> ACC_FRAC_BITS_DEF;
      rep.pwm_duty = mag[12:0];
      // direction only means something with a nonzero duty
      if (mag != 0)
        rep.reverse_drive = (drive_acc < 0) ^ loop_cfg.reverse_polarity;
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // gap or stall length: mostly short, a few long
  function automatic int idle_len();
    int roll;
    if (quiet)
      return 0;
    roll = rand_between(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 88)
      return rand_between(1, 3);
    if (roll < 98)
      return rand_between(4, 12);
    return rand_between(20, 60);
  endfunction

  // register value: extremes, a useful range or anything, with junk above the width
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_ADDR_W-1:0] idx);
    int w, lo, hi, roll;
    logic [CFG_DATA_W-1:0] v, ones;
    case (idx)
      CFG_COUNT_SCALE:      begin w = 16; lo = 1024; hi = 8192;  end
      CFG_SPEED_LIMIT:      begin w = 15; lo = 2048; hi = 16384; end
      CFG_FILTER_ALPHA:     begin w = 17; lo = 4096; hi = 65536; end
      CFG_PROP_GAIN:        begin w = 24; lo = 0;    hi = 16384; end
      CFG_INTEGRAL_GAIN:    begin w = 24; lo = 0;    hi = 8192;  end
      CFG_REVERSE_POLARITY: begin w = 1;  lo = 0;    hi = 1;     end
      default:              begin w = 13; lo = 1000; hi = 8191;  end
    endcase
    ones = (24'd1 << w) - 24'd1;
    roll = rand_between(0, 19);
    if (roll == 0)
      v = '0;
    else if (roll == 1)
      v = ones;
    else if (roll < 13)
      v = CFG_DATA_W'(rand_between(lo, hi));
    else
      v = CFG_DATA_W'($urandom) & ones;
    if (rand_between(0, 3) == 0)
      v = v | (CFG_DATA_W'($urandom) & ~ones);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // bus tasks
  // ---------------------------------------------------------------------------
  // one register write per edge; the caller drops cfg_we after the batch
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    store_reg(idx, val);
  endtask

  // offer one tick, wait for the handshake, then book its result
  task automatic send_tick(input logic signed [15:0] count,
                           input logic signed [13:0] target,
                           input logic known, input wheel_report_t want);
    int gap;
    wheel_report_t calc;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, target, count};
    do @(posedge clk); while (!s_tready);
    // model always advances, even where the table gives the answer
    calc = step_wheel(count, target);
    due_reports.push_back(known ? want : calc);
  endtask

  // hold off until every booked result has come back, then let the block settle
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // directed table builders
  function automatic void plan_write(input logic [CFG_ADDR_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_tick(input logic signed [15:0] count,
                                    input logic signed [13:0] target);
    plan_row_t row;
    row = '0;
    row.kind   = ROW_TICK;
    row.count  = count;
    row.target = target;
    plan.push_back(row);
  endfunction

  function automatic void plan_tick_known(input logic signed [15:0] count,
                                          input logic signed [13:0] target,
                                          input logic [12:0] duty, input logic rev,
                                          input logic signed [15:0] speed,
                                          input logic stop);
    plan_row_t row;
    row = '0;
    row.kind   = ROW_TICK;
    row.count  = count;
    row.target = target;
    row.known  = 1'b1;
    row.want   = '{stopped: stop, measured_speed: speed, reverse_drive: rev,
                   pwm_duty: duty};
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls on m_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && rand_between(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= idle_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result check and watchdog
  // ---------------------------------------------------------------------------
  wheel_report_t got_rep, want_rep;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rep = m_tdata[30:0];
      if (due_reports.size() == 0) begin
        $error("result item with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want_rep = due_reports.pop_front();
        if (got_rep.pwm_duty !== want_rep.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want_rep.pwm_duty, got_rep.pwm_duty);
          errors++;
        end
        if (got_rep.reverse_drive !== want_rep.reverse_drive) begin
          $error("reverse_drive: expected %0d, got %0d",
                 want_rep.reverse_drive, got_rep.reverse_drive);
          errors++;
        end
        if (got_rep.measured_speed !== want_rep.measured_speed) begin
          $error("measured_speed: expected %0d, got %0d",
                 $signed(want_rep.measured_speed), $signed(got_rep.measured_speed));
          errors++;
        end
        if (got_rep.stopped !== want_rep.stopped) begin
          $error("stopped: expected %0d, got %0d", want_rep.stopped, got_rep.stopped);
          errors++;
        end
      end
    end

    // nothing moving on either side for too long means the block hung
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bit                 writing;
    int                 sent, run, base, cnt;
    logic signed [13:0] tgt;

    // model starts from the reset defaults
    loop_cfg.count_scale      = COUNT_SCALE_RESET;
    loop_cfg.speed_limit      = SPEED_LIMIT_RESET;
    loop_cfg.filter_alpha     = FILTER_ALPHA_RESET;
    loop_cfg.prop_gain        = PROP_GAIN_RESET;
    loop_cfg.integral_gain    = INTEGRAL_GAIN_RESET;
    loop_cfg.reverse_polarity = 1'b0;
    loop_cfg.pwm_limit        = PWM_LIMIT_RESET;
    filt_speed = 0;
    drive_acc  = 0;
    last_error = 0;
    writing    = 1'b0;

    // directed table: defaults, stop rule edges, saturation, zero duty,
    // polarity, register extremes and masking, the unmapped index
    plan_tick_known(0, 0, 0, 0, 0, 1);          // right after reset: stopped, all zero
    plan_tick(0, 4096);
    plan_tick(32767, 4096);                     // clamped to the speed limit
    plan_tick(-32768, -4096);
    plan_tick(0, 0);
    plan_write(CFG_FILTER_ALPHA, 24'd65536);    // filter passes the new sample
    plan_tick_known(0, 0, 0, 0, 0, 1);
    plan_tick_known(1000, 0, 0, 0, 1000, 1);    // slow wheel still stops
    plan_tick(4096, 0);                         // exactly 1.0: no stop
    plan_tick_known(-4095, 0, 0, 0, -4095, 1);
    plan_write(CFG_PROP_GAIN, 24'hFFFFFF);
    plan_write(CFG_INTEGRAL_GAIN, 24'hFFFFFF);
    plan_tick_known(0, 4096, 7200, 0, 0, 0);    // saturates at the default limit
    plan_tick(0, -4096);
    plan_tick(0, -4096);
    plan_write(CFG_PWM_LIMIT, 24'd0);
    plan_tick_known(0, 4096, 0, 0, 0, 0);       // zero duty, no direction
    plan_write(CFG_PWM_LIMIT, 24'hFFFFFF);      // keeps 8191
    plan_tick(0, 4096);
    plan_tick(0, 4096);
    plan_write(CFG_REVERSE_POLARITY, 24'hFFFFFF);
    plan_tick(0, 4096);
    plan_tick(4096, 2000);
    plan_write(CFG_COUNT_SCALE, 24'hFFFFFF);    // keeps 65535
    plan_write(CFG_SPEED_LIMIT, 24'hFFFFFF);    // keeps 32767
    plan_write(CFG_FILTER_ALPHA, 24'h1FFFF);    // above one acts as one
    plan_write(CFG_PROP_GAIN, 24'd4096);
    plan_write(CFG_INTEGRAL_GAIN, 24'd4096);
    plan_tick(32767, 4096);
    plan_tick(-32768, -4096);
    plan_write(CFG_COUNT_SCALE, 24'd0);
    plan_write(CFG_FILTER_ALPHA, 24'd0);        // filter frozen
    plan_write(CFG_SPEED_LIMIT, 24'd0);
    plan_tick(12345, 100);
    plan_tick(-1, 0);                           // large held speed, target zero
    plan_write(CFG_UNMAPPED, 24'hFFFFFF);       // must change nothing
    plan_write(CFG_FILTER_ALPHA, 24'd1);
    plan_write(CFG_PROP_GAIN, 24'd0);
    plan_write(CFG_INTEGRAL_GAIN, 24'd0);
    plan_write(CFG_REVERSE_POLARITY, 24'd0);
    plan_tick(5, 0);
    plan_tick(-32768, -1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // walk the table; writes only go in once the block has gone idle
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) begin
          wait_for_results();
          writing = 1'b1;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_tick(plan[i].count, plan[i].target, plan[i].known, plan[i].want);
      end
    end
    if (writing)
      cfg_we <= 1'b0;

    // random phases: fresh settings, then runs of ticks with a held target
    // and encoder counts near a base, some noise mixed in
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_results();
      quiet = (ph % 3 == 1);
      for (int r = 0; r < 7; r++)
        write_reg(r[CFG_ADDR_W-1:0], pick_reg_value(r[CFG_ADDR_W-1:0]));
      if (rand_between(0, 3) == 0)
        write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // target: often zero so the stop rule gets its chances
        case (rand_between(0, 9))
          0, 1, 2: tgt = 0;
          3:       tgt = 14'sd4096;
          4:       tgt = -14'sd4096;
          default: tgt = 14'(rand_between(-4096, 4096));
        endcase
        // wheel speed regime: near still, moderate, or anything
        case (rand_between(0, 9))
          0, 1, 2, 3: base = rand_between(-8, 8);
          4, 5, 6, 7: base = rand_between(-2000, 2000);
          default:    base = rand_between(-32768, 32767);
        endcase
        run = rand_between(1, 24);
        for (int k = 0; k < run && sent < ITEMS_PER_PHASE; k++) begin
          if (rand_between(0, 19) == 0)
            cnt = rand_between(-32768, 32767);
          else
            cnt = base + rand_between(-3, 3);
          if (cnt > 32767)
            cnt = 32767;
          if (cnt < -32768)
            cnt = -32768;
          send_tick(16'(cnt), tgt, 1'b0, '0);
          sent++;
        end
        // now and then the sender waits for the output side to empty
        if (rand_between(0, 49) == 0)
          wait_for_results();
      end
    end

    wait_for_results();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
